>>> design/rnc_pkg.sv
// shared types, constants and the sine table for the retuning notch cascade
package rnc_pkg;

  localparam int NUM_STAGES = 3;
  localparam int TRIG_DEPTH = 1024;
  localparam int TRIG_LOG = $clog2(TRIG_DEPTH);
  localparam int QUAD_LOG = TRIG_LOG - 2;
  localparam int QUAD_DEPTH = TRIG_DEPTH / 4;

  localparam int COEF_W = 20;
  localparam int SAMP_W = 24;
  localparam int TRIG_W = 18;
  localparam int NUM_W = 37;
  localparam int MAG_W = NUM_W - 1;
  localparam int DEN_W = 20;
  localparam int DMAG_W = DEN_W - 1;

  localparam logic [2:0] PADDR_REG_SAMPLE_RATE = 3'd0;
  localparam logic [15:0] SAMPLE_RATE_RESET = 16'd16000;
  localparam logic [5:0] Q_RESET = 6'd30;
  localparam logic [14:0] FREQ_STEP = 15'd10;
  localparam logic [5:0] Q_STEP = 6'd1;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 20'sd524287;
  localparam logic signed [COEF_W-1:0] COEF_MIN = -20'sd524288;
  localparam logic signed [SAMP_W-1:0] SAMP_MAX = 24'sd8388607;
  localparam logic signed [SAMP_W-1:0] SAMP_MIN = -24'sd8388608;
  localparam logic signed [COEF_W-1:0] C0_RESET = 20'sd65536;
  localparam logic signed [COEF_W-1:0] C1_RESET = -20'sd131072;
  localparam logic signed [COEF_W-1:0] C2_RESET = 20'sd65536;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [SAMP_W-1:0] samp_t;
  typedef logic [16:0] qsin_tab_t [QUAD_DEPTH];

  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_MAC,
    CELL_OUT,
    CELL_DIV_IDX,
    CELL_DIV_ALPHA,
    CELL_DIV_C0,
    CELL_DIV_C1,
    CELL_DIV_C2
  } cell_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic busy;
    logic filtering;
  } cell_status_t;

  typedef struct packed {
    logic        we;
    logic [14:0] freq;
    logic [5:0]  q;
  } goal_wr_t;

  // sine over a quarter turn in q30, taylor series in horner form
  function automatic logic [63:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t = ONE_Q30 - x2 / 64'd110;
    t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  function automatic logic [16:0] q30_to_q16(input logic [63:0] v);
    logic [63:0] w;
    w = (v + 64'd8192) >> 14;
    return w[16:0];
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    for (int i = 0; i < QUAD_DEPTH; i++) begin
      tab[i] = q30_to_q16(quarter_sine(64'(i) << (30 - QUAD_LOG)));
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();
  localparam logic [16:0] QSIN_TOP = q30_to_q16(quarter_sine(ONE_Q30));

  function automatic coef_t sat_coef(input logic signed [NUM_W-1:0] v);
    if (v > NUM_W'(COEF_MAX)) begin
      return COEF_MAX;
    end else if (v < NUM_W'(COEF_MIN)) begin
      return COEF_MIN;
    end
    return v[COEF_W-1:0];
  endfunction

endpackage

>>> design/rnc_div.sv
// signed restoring divider, one quotient bit per cycle, truncates toward zero
module rnc_div import rnc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic signed [NUM_W-1:0] quo,
  output div_status_t             status
);

  logic [MAG_W-1:0]  nq;
  logic [DMAG_W-1:0] rem;
  logic [DMAG_W-1:0] dv;
  logic              neg;
  logic [5:0]        cnt;
  logic              busy;
  logic              done;

  logic [NUM_W-1:0]  num_abs;
  logic [DEN_W-1:0]  den_abs;
  logic [DMAG_W:0]   sh;
  logic              fits;

  always_comb begin
    num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    den_abs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    sh = {rem, nq[MAG_W-1]};
    fits = sh >= {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt <= 6'(MAG_W);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      nq <= num_abs[MAG_W-1:0];
      dv <= den_abs[DMAG_W-1:0];
      rem <= '0;
      neg <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy) begin
      rem <= fits ? DMAG_W'(sh - {1'b0, dv}) : sh[DMAG_W-1:0];
      nq <= {nq[MAG_W-2:0], fits};
    end
  end

  assign quo = neg ? -$signed({1'b0, nq}) : $signed({1'b0, nq});
  assign status = '{busy: busy, done: done};

endmodule

>>> design/rnc_cell.sv
// one notch stage: biquad multiply-accumulate and coefficient retuning
module rnc_cell import rnc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         x_valid,
  input  samp_t        x,
  input  goal_wr_t     goal,
  input  logic [15:0]  fs,
  output logic         y_valid,
  output samp_t        y,
  output cell_status_t status
);

  cell_state_t state, state_next;

  logic [2:0]  cnt;
  coef_t       c0, c1, c2;
  samp_t       x_cur, h0, h1, y0, y1;
  logic signed [COEF_W+SAMP_W-1:0] prod;
  logic        sub;
  logic signed [47:0] acc;
  logic [14:0] freq, goal_freq, freq_next;
  logic [5:0]  q, goal_q, q_next;
  logic [TRIG_LOG-1:0] idx;
  logic signed [19:0] alpha;
  logic signed [DEN_W-1:0] den;

  logic signed [47:0] y_full;
  samp_t       y_sat;
  coef_t       op_c;
  samp_t       op_x;
  logic        op_sub;

  logic [QUAD_LOG-1:0] qi;
  logic [16:0] sn, cs;
  logic signed [TRIG_W-1:0] s, c;
  logic signed [20:0] s5;
  logic [5:0]  qt;
  logic signed [20:0] den_wide;
  logic signed [16:0] fdiff;
  logic signed [6:0]  qdiff;

  logic                    div_start;
  logic signed [NUM_W-1:0] div_num;
  logic signed [DEN_W-1:0] div_den;
  logic signed [NUM_W-1:0] div_quo;
  div_status_t             dstat;

  rnc_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quo    (div_quo),
    .status (dstat)
  );

  // sine and cosine from the quarter-wave table
  always_comb begin
    qi = idx[QUAD_LOG-1:0];
    sn = QSIN_TAB[qi];
    cs = (qi == '0) ? QSIN_TOP : QSIN_TAB[QUAD_LOG'(QUAD_DEPTH - int'(qi))];
    case (idx[TRIG_LOG-1:TRIG_LOG-2])
      2'd0: begin s = $signed({1'b0, sn}); c = $signed({1'b0, cs}); end
      2'd1: begin s = $signed({1'b0, cs}); c = -$signed({1'b0, sn}); end
      2'd2: begin s = -$signed({1'b0, sn}); c = -$signed({1'b0, cs}); end
      default: begin s = -$signed({1'b0, cs}); c = $signed({1'b0, sn}); end
    endcase
    s5 = (21'(s) <<< 2) + 21'(s);
    qt = (q == '0) ? 6'd1 : q;
  end

  always_comb begin
    case (cnt)
      3'd0: begin op_c = c0; op_x = x_cur; op_sub = 1'b0; end
      3'd1: begin op_c = c1; op_x = h0; op_sub = 1'b0; end
      3'd2: begin op_c = c0; op_x = h1; op_sub = 1'b0; end
      3'd3: begin op_c = c1; op_x = y0; op_sub = 1'b1; end
      default: begin op_c = c2; op_x = y1; op_sub = 1'b1; end
    endcase
    y_full = (acc + 48'sd32768) >>> 16;
    if (y_full > 48'(SAMP_MAX)) begin
      y_sat = SAMP_MAX;
    end else if (y_full < 48'(SAMP_MIN)) begin
      y_sat = SAMP_MIN;
    end else begin
      y_sat = y_full[SAMP_W-1:0];
    end
  end

  // step current frequency and q toward their goals
  always_comb begin
    fdiff = $signed({2'b0, goal_freq}) - $signed({2'b0, freq});
    if (fdiff > $signed({2'b0, FREQ_STEP})) begin
      freq_next = freq + FREQ_STEP;
    end else if (fdiff < -$signed({2'b0, FREQ_STEP})) begin
      freq_next = freq - FREQ_STEP;
    end else begin
      freq_next = goal_freq;
    end
    qdiff = $signed({1'b0, goal_q}) - $signed({1'b0, q});
    if (qdiff > $signed({1'b0, Q_STEP})) begin
      q_next = q + Q_STEP;
    end else if (qdiff < -$signed({1'b0, Q_STEP})) begin
      q_next = q - Q_STEP;
    end else begin
      q_next = goal_q;
    end
    den_wide = 21'sd65536 + 21'($signed(div_quo[19:0]));
  end

  always_comb begin
    div_num = '0;
    div_den = 20'sd1;
    case (state)
      CELL_DIV_IDX: begin
        div_num = $signed(NUM_W'({freq, {TRIG_LOG{1'b0}}}));
        div_den = $signed(DEN_W'(fs));
      end
      CELL_DIV_ALPHA: begin
        div_num = NUM_W'(s5);
        div_den = $signed(DEN_W'(qt));
      end
      CELL_DIV_C0: begin
        div_num = 37'sh1_0000_0000;
        div_den = den;
      end
      CELL_DIV_C1: begin
        div_num = -(NUM_W'(c) <<< 17);
        div_den = den;
      end
      CELL_DIV_C2: begin
        div_num = NUM_W'(21'sd65536 - 21'(alpha)) <<< 16;
        div_den = den;
      end
      default: begin
        div_num = '0;
        div_den = 20'sd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CELL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    y_valid = 1'b0;
    unique case (state)
      CELL_IDLE: begin
        if (x_valid) begin
          state_next = CELL_MAC;
        end
      end
      CELL_MAC: begin
        if (cnt == 3'd5) begin
          state_next = CELL_OUT;
        end
      end
      CELL_OUT: begin
        y_valid = 1'b1;
        state_next = CELL_DIV_IDX;
      end
      CELL_DIV_IDX: begin
        if (fs == '0) begin
          state_next = CELL_DIV_ALPHA;
        end else begin
          div_start = !dstat.busy && !dstat.done;
          if (dstat.done) begin
            state_next = CELL_DIV_ALPHA;
          end
        end
      end
      CELL_DIV_ALPHA: begin
        div_start = !dstat.busy && !dstat.done;
        if (dstat.done) begin
          state_next = CELL_DIV_C0;
        end
      end
      CELL_DIV_C0: begin
        div_start = !dstat.busy && !dstat.done;
        if (dstat.done) begin
          state_next = CELL_DIV_C1;
        end
      end
      CELL_DIV_C1: begin
        div_start = !dstat.busy && !dstat.done;
        if (dstat.done) begin
          state_next = CELL_DIV_C2;
        end
      end
      CELL_DIV_C2: begin
        div_start = !dstat.busy && !dstat.done;
        if (dstat.done) begin
          state_next = CELL_IDLE;
        end
      end
      default: begin
        state_next = CELL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      acc <= '0;
      prod <= '0;
      sub <= 1'b0;
      h0 <= '0;
      h1 <= '0;
      y0 <= '0;
      y1 <= '0;
      freq <= '0;
      goal_freq <= '0;
      q <= Q_RESET;
      goal_q <= Q_RESET;
      c0 <= C0_RESET;
      c1 <= C1_RESET;
      c2 <= C2_RESET;
      idx <= '0;
      alpha <= '0;
      den <= 20'sd1;
    end else begin
      if (goal.we) begin
        goal_freq <= goal.freq;
        goal_q <= goal.q;
      end
      case (state)
        CELL_IDLE: begin
          if (x_valid) begin
            x_cur <= x;
            cnt <= '0;
            acc <= '0;
          end
        end
        CELL_MAC: begin
          prod <= op_c * op_x;
          sub <= op_sub;
          if (cnt != 3'd0) begin
            acc <= sub ? acc - 48'(prod) : acc + 48'(prod);
          end
          cnt <= cnt + 3'd1;
        end
        CELL_OUT: begin
          h1 <= h0;
          h0 <= x_cur;
          y1 <= y0;
          y0 <= y_sat;
          freq <= freq_next;
          q <= q_next;
        end
        CELL_DIV_IDX: begin
          if (fs == '0) begin
            idx <= '0;
          end else if (dstat.done) begin
            idx <= div_quo[TRIG_LOG-1:0];
          end
        end
        CELL_DIV_ALPHA: begin
          if (dstat.done) begin
            alpha <= div_quo[19:0];
            den <= (den_wide == '0) ? 20'sd1 : den_wide[DEN_W-1:0];
          end
        end
        CELL_DIV_C0: begin
          if (dstat.done) begin
            c0 <= sat_coef(div_quo);
          end
        end
        CELL_DIV_C1: begin
          if (dstat.done) begin
            c1 <= sat_coef(div_quo);
          end
        end
        CELL_DIV_C2: begin
          if (dstat.done) begin
            c2 <= sat_coef(div_quo);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign y = y_sat;
  assign status = '{busy: state != CELL_IDLE,
                    filtering: (state == CELL_MAC) || (state == CELL_OUT)};

endmodule

>>> design/retuning_notch_filter_cascade_top.sv
// top level: input and output channels, config register, chain of notch cells
//
// Input channel (in_valid/in_stall) takes either an audio sample (req_type 0)
// or a set-target item (req_type 1) that loads one stage's goal frequency
// and Q; set-target items for a stage past the last one are dropped.
// Each sample runs through the cells in order; each cell does five
// multiply-accumulates and hands its output to the next one, the last
// cell to the output register.
// After filtering, every cell retunes itself with its own bit-serial divider:
// five divisions (table index, alpha, three coefficients); with sample_rate_hz
// at 0 the table index division is skipped and the index is set to 0.
// One item at a time: after a sample the next item is taken only once every
// cell has finished its retuning.
// A set-target item gives no output and starts no filtering or retuning.
// The output register holds sample_out until the receiver drops out_stall;
// no new item is taken while a result waits.
// Reset (synchronous, rst) clears the histories, sets all stages to 0 Hz
// (pass-through) with Q 3.0, and sample_rate_hz to 16000.
// sample_rate_hz sits at APB address 0 and is to be written only while idle; the block itself does not enforce this.
module retuning_notch_filter_cascade_top import rnc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic signed [15:0] sample_in,
  input  logic [2:0]  stage_index,
  input  logic [14:0] target_freq_hz,
  input  logic [5:0]  target_q_tenths,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] sample_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] fs;
  logic        in_xfer;
  logic        busy_any;
  logic [NUM_STAGES-1:0] filt_vec;

  samp_t        x_chain [NUM_STAGES+1];
  logic         v_chain [NUM_STAGES+1];
  cell_status_t cst [NUM_STAGES];
  goal_wr_t     gw [NUM_STAGES];

  logic signed [24:0] out_round;
  logic signed [16:0] out_full;

  assign pready = 1'b1;
  assign prdata = (paddr == PADDR_REG_SAMPLE_RATE) ? {16'b0, fs} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fs <= SAMPLE_RATE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == PADDR_REG_SAMPLE_RATE) begin
      fs <= pwdata[15:0];
    end
  end

  always_comb begin
    busy_any = 1'b0;
    for (int k = 0; k < NUM_STAGES; k++) begin
      busy_any = busy_any | cst[k].busy;
      filt_vec[k] = cst[k].filtering;
    end
  end

  assign in_stall = busy_any | out_valid;
  assign in_xfer = in_valid && !in_stall;
  assign v_chain[0] = in_xfer && !req_type;
  assign x_chain[0] = SAMP_W'(sample_in) <<< 8;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
    assign gw[k] = '{we: in_xfer && req_type && (stage_index == 3'(k)),
                     freq: target_freq_hz, q: target_q_tenths};
    rnc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .x_valid (v_chain[k]),
      .x       (x_chain[k]),
      .goal    (gw[k]),
      .fs      (fs),
      .y_valid (v_chain[k+1]),
      .y       (x_chain[k+1]),
      .status  (cst[k])
    );
  end

  // round the last stage back to 16 bits, halves up
  always_comb begin
    out_round = (25'(x_chain[NUM_STAGES]) + 25'sd128) >>> 8;
    out_full = out_round[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (v_chain[NUM_STAGES]) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v_chain[NUM_STAGES]) begin
      if (out_full > 17'sd32767) begin
        sample_out <= 16'sd32767;
      end else if (out_full < -17'sd32768) begin
        sample_out <= -16'sd32768;
      end else begin
        sample_out <= out_full[15:0];
      end
    end
  end

  a_one_filtering: assert property (@(posedge clk) disable iff (rst)
    $onehot0(filt_vec)) else $error("two cells filtering at once");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !req_type |=> cst[0].busy)
    else $error("first cell did not take the sample");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    v_chain[NUM_STAGES] |=> out_valid)
    else $error("last cell output not registered");

endmodule

>>> verif/retuning_notch_filter_cascade_top_test.sv
// self-checking testbench for the retuning notch filter cascade
module retuning_notch_filter_cascade_top_test;
  import rnc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 320;
  localparam longint Q30_ONE = 64'd1 << 30;
  localparam longint Q30_HALF_PI = 64'd1686629713;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic signed [15:0] sample_in = '0;
  logic [2:0] stage_index = '0;
  logic [14:0] target_freq_hz = '0;
  logic [5:0] target_q_tenths = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] sample_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  retuning_notch_filter_cascade_top dut (.*);

  always #5 clk = ~clk;

  // filter model state
  logic [15:0] fs_hz;
  longint xh [NUM_STAGES][2];
  longint yh [NUM_STAGES][2];
  int cur_f [NUM_STAGES];
  int goal_f [NUM_STAGES];
  int cur_q [NUM_STAGES];
  int goal_q [NUM_STAGES];
  longint coef [NUM_STAGES][3];

  logic signed [15:0] pending_out [$];
  int mismatches = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  int idle_cycles = 0;

  function automatic longint unsigned sine_q30(longint unsigned r);
    longint unsigned x, x2, t;
    x = (r * Q30_HALF_PI) >> 30;
    x2 = (x * x) >> 30;
    t = Q30_ONE - x2 / 110;
    t = Q30_ONE - ((x2 * t) >> 30) / 72;
    t = Q30_ONE - ((x2 * t) >> 30) / 42;
    t = Q30_ONE - ((x2 * t) >> 30) / 20;
    t = Q30_ONE - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void retune(int k);
    longint unsigned idx, p, r;
    longint sn, cs, s, c, qt, alpha, den;
    idx = 0;
    if (fs_hz != 0) idx = (longint'(cur_f[k]) * TRIG_DEPTH / fs_hz) % TRIG_DEPTH;
    p = (idx << 32) / TRIG_DEPTH;
    r = p & (Q30_ONE - 1);
    sn = longint'((sine_q30(r) + 8192) >> 14);
    cs = longint'((sine_q30(Q30_ONE - r) + 8192) >> 14);
    case ((p >> 30) & 3)
      0: begin s = sn; c = cs; end
      1: begin s = cs; c = -sn; end
      2: begin s = -sn; c = -cs; end
      default: begin s = -cs; c = sn; end
    endcase
    qt = cur_q[k] != 0 ? cur_q[k] : 1;
    alpha = (s * 5) / qt;
    den = 65536 + alpha;
    if (den == 0) den = 1;
    coef[k][0] = clamp((64'sd65536 * 65536) / den, COEF_MIN, COEF_MAX);
    coef[k][1] = clamp((-2 * c * 65536) / den, COEF_MIN, COEF_MAX);
    coef[k][2] = clamp(((65536 - alpha) * 65536) / den, COEF_MIN, COEF_MAX);
  endfunction

  function automatic int step_toward(int cur, int goal, int stp);
    if (goal - cur > stp) return cur + stp;
    if (goal - cur < -stp) return cur - stp;
    return goal;
  endfunction

  function automatic void reset_cascade();
    fs_hz = SAMPLE_RATE_RESET;
    for (int k = 0; k < NUM_STAGES; k++) begin
      xh[k] = '{0, 0};
      yh[k] = '{0, 0};
      cur_f[k] = 0;
      goal_f[k] = 0;
      cur_q[k] = Q_RESET;
      goal_q[k] = Q_RESET;
      retune(k);
    end
  endfunction

  // returns the filtered sample
  function automatic logic signed [15:0] filter_sample(logic signed [15:0] smp);
    longint x, y, acc;
    x = longint'(smp) * 256;
    for (int k = 0; k < NUM_STAGES; k++) begin
      acc = coef[k][0] * x + coef[k][1] * xh[k][0] + coef[k][0] * xh[k][1]
          - coef[k][1] * yh[k][0] - coef[k][2] * yh[k][1];
      y = clamp((acc + 32768) >>> 16, SAMP_MIN, SAMP_MAX);
      xh[k][1] = xh[k][0];
      xh[k][0] = x;
      yh[k][1] = yh[k][0];
      yh[k][0] = y;
      cur_f[k] = step_toward(cur_f[k], goal_f[k], FREQ_STEP);
      cur_q[k] = step_toward(cur_q[k], goal_q[k], Q_STEP);
      retune(k);
      x = y;
    end
    return 16'(clamp((x + 128) >>> 8, -32768, 32767));
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // one input transfer; known=1 uses the typed-in expectation
  task automatic send_item(bit rt, logic signed [15:0] smp, logic [2:0] st,
                           logic [14:0] f, logic [5:0] q, bit known,
                           logic signed [15:0] known_out);
    int gap;
    logic signed [15:0] pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    sample_in <= smp;
    stage_index <= st;
    target_freq_hz <= f;
    target_q_tenths <= q;
    do @(posedge clk); while (in_stall);
    if (rt) begin
      if (st < NUM_STAGES) begin
        goal_f[st] = f;
        goal_q[st] = q;
      end
    end else begin
      pred = filter_sample(smp);
      pending_out.push_back(known ? known_out : pred);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_REG_SAMPLE_RATE;
    pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    fs_hz = v;
    @(posedge clk);
  endtask

  typedef struct {
    bit rt;
    logic signed [15:0] smp;
    logic [2:0] st;
    logic [14:0] f;
    logic [5:0] q;
    bit known;
    logic signed [15:0] res;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{0, 16'sd0, 0, 0, 0, 1, 16'sd0},
    '{0, 16'sd32767, 0, 0, 0, 1, 16'sd32767},
    '{0, -16'sd32768, 0, 0, 0, 1, -16'sd32768},
    '{0, 16'sd1, 0, 0, 0, 1, 16'sd1},
    '{0, -16'sd1, 0, 0, 0, 1, -16'sd1},
    '{1, 16'sd0, 7, 15'h7fff, 6'h3f, 0, 16'sd0},   // stage out of range
    '{1, 16'sd0, 3, 1000, 20, 0, 16'sd0},
    '{0, 16'sd100, 0, 0, 0, 1, 16'sd100},
    '{1, 16'sd0, 0, 1000, 0, 0, 16'sd0},           // q of zero
    '{1, 16'sd0, 1, 24000, 50, 0, 16'sd0},
    '{1, 16'sd0, 2, 15'h7fff, 10, 0, 16'sd0},
    '{0, 16'sd12345, 0, 0, 0, 1, 16'sd12345},      // retune waits for a sample
    '{0, 16'sd32767, 0, 0, 0, 0, 16'sd0},
    '{0, -16'sd32768, 0, 0, 0, 0, 16'sd0},
    '{0, 16'sd32767, 0, 0, 0, 0, 16'sd0},
    '{0, 16'sd32767, 0, 0, 0, 0, 16'sd0},
    '{0, -16'sd32768, 0, 0, 0, 0, 16'sd0},
    '{0, -16'sd32768, 0, 0, 0, 0, 16'sd0},
    '{0, 16'sd0, 0, 0, 0, 0, 16'sd0},
    '{0, 16'sd21000, 0, 0, 0, 0, 16'sd0},
    '{0, -16'sd777, 0, 0, 0, 0, 16'sd0},
    '{0, 16'sd5, 0, 0, 0, 0, 16'sd0},
    '{1, 16'sd0, 0, 0, 30, 0, 16'sd0},
    '{0, 16'sd30000, 0, 0, 0, 0, 16'sd0},
    '{0, -16'sd30000, 0, 0, 0, 0, 16'sd0}
  };

  // fs of 40 with a 30 Hz goal lands on the -1 sine entry; q 0.5 zeroes the denominator
  logic [15:0] rate_plan [] = '{16'd40, 16'd16000, 16'd8000, 16'd48000, 16'd0,
                               16'd65535, 16'd44100, 16'd0};

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm || $urandom_range(0, 99) < 60) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 99) < 90 ? $urandom_range(0, 2)
                                                 : $urandom_range(10, 60);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample_out %0d", sample_out);
      end else begin
        if (sample_out !== pending_out[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample_out mismatch: expected %0d, got %0d", pending_out[0], sample_out);
        end
        void'(pending_out.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("retuning_notch_filter_cascade_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] fs;
    int r;
    logic [2:0] st;
    logic [14:0] f;
    logic [5:0] q;
    logic signed [15:0] smp;
    reset_cascade();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i])
      send_item(directed[i].rt, directed[i].smp, directed[i].st, directed[i].f,
                directed[i].q, directed[i].known, directed[i].res);
    foreach (rate_plan[p]) begin
      drain();
      fs = (p == rate_plan.size() - 1) ? 16'($urandom_range(8000, 48000)) : rate_plan[p];
      write_rate(fs);
      calm = (p % 3 == 2);
      if (fs == 16'd40) send_item(1, 0, 0, 30, 5, 0, 0);
      for (int i = 0; i < 130; i++) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          r = $urandom_range(0, 99);
          if (r < 75) smp = 16'($urandom);
          else if (r < 85) smp = 16'sd32767;
          else if (r < 95) smp = -16'sd32768;
          else smp = 16'($urandom_range(0, 15)) - 16'sd8;
          send_item(0, smp, 3'($urandom), 15'($urandom), 6'($urandom), 0, 0);
        end else begin
          st = $urandom_range(0, 99) < 85 ? 3'($urandom_range(0, NUM_STAGES - 1))
                                          : 3'($urandom);
          if (fs == 16'd40 && i < 60 && st == 0) st = 1;
          r = $urandom_range(0, 99);
          if (r < 60) f = 15'($urandom_range(0, 2000));
          else if (r < 85) f = 15'($urandom_range(0, 24000));
          else f = 15'($urandom);
          q = $urandom_range(0, 99) < 85 ? 6'($urandom_range(10, 50)) : 6'($urandom);
          send_item(1, 16'($urandom), st, f, q, 0, 0);
        end
      end
    end
    drain();
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("retuning_notch_filter_cascade_top verification clean");
    end else begin
      $display("retuning_notch_filter_cascade_top verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rnc_pkg.sv
design/rnc_div.sv
design/rnc_cell.sv
design/retuning_notch_filter_cascade_top.sv
verif/retuning_notch_filter_cascade_top_test.sv
